// File: design/bwfsa_pkg.sv
package bwfsa_pkg;

	// function codes of a command
	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE  = 1'b1;

	// status codes of a result
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FIT   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE = 2'd1;

	// fit mode values
	localparam logic FIT_BEST  = 1'b0;
	localparam logic FIT_WORST = 1'b1;

	// reset length of the initial hole
	localparam logic [15:0] MEM_SIZE_RST = 16'hFFFF;

	// operations broadcast to every cell of the table
	typedef enum logic [2:0] {
		ED_NONE,
		ED_INIT,
		ED_SET_OWNER,
		ED_SET_LEN,
		ED_INSERT,
		ED_REMOVE
	} ed_op_t;

	typedef struct packed {
		logic        func;
		logic [7:0]  proc_id;
		logic [15:0] req_size;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] leftover;
		logic [15:0] merged_size;
	} rsp_t;

endpackage

// File: design/bwfsa_cell.sv
module bwfsa_cell #(
	parameter int IDX = 0,
	parameter int IW = 4,
	parameter int CW = 5,
	parameter int SW = 16,
	parameter type entry_t = logic,
	parameter type probe_t = logic,
	parameter type edit_t = logic
) (
	input  logic   clk,
	input  logic   arst_n,
	input  edit_t  edit,
	input  entry_t left,
	input  entry_t right,
	output entry_t ent,
	input  probe_t probe_in,
	output probe_t probe_out
);
	import bwfsa_pkg::*;

	localparam logic [IW-1:0] MY = IW'(IDX);

	entry_t ent_q;
	entry_t ent_d;
	probe_t probe_q;
	probe_t probe_d;
	logic in_range;
	logic hole;
	logic fits;
	logic better;
	logic match;
	logic [SW-1:0] rest;

	// table edits: every cell decides from its own index against the position
	always_comb begin
		ent_d = ent_q;
		unique case (edit.op)
			ED_NONE: ;
			ED_INIT: begin
				ent_d.owner = '0;
				ent_d.len = (IDX == 0) ? edit.len : '0;
			end
			ED_SET_OWNER: if (MY == edit.pos) ent_d.owner = edit.owner;
			ED_SET_LEN: if (MY == edit.pos) ent_d.len = edit.len;
			ED_INSERT: begin
				if (MY > edit.pos) begin
					ent_d = left;
				end else if (MY == edit.pos) begin
					ent_d.owner = edit.owner;
					ent_d.len = edit.len;
				end
			end
			ED_REMOVE: if (MY >= edit.pos) ent_d = right;
			default: ;
		endcase
	end

	// probe evaluation as it passes this cell
	always_comb begin
		probe_d = probe_in;
		in_range = CW'(MY) < probe_in.cnt;
		hole = in_range && (ent_q.owner == '0);
		rest = ent_q.len - probe_in.req;
		fits = hole && (ent_q.len >= probe_in.req);
		better = (probe_in.worst == FIT_WORST) ? (rest > probe_in.best) : (rest < probe_in.best);
		match = 1'b0;
		if (probe_in.func == FN_ALLOC) begin
			if (fits && (!probe_in.found || better)) begin
				probe_d.found = 1'b1;
				probe_d.best = rest;
				probe_d.pos = MY;
			end
		end else begin
			match = in_range && (probe_in.id != '0) && (ent_q.owner == probe_in.id) &&
				!probe_in.found;
			if (match) begin
				probe_d.found = 1'b1;
				probe_d.pos = MY;
				probe_d.prev_hole = probe_in.last_hole;
				probe_d.prev_len = probe_in.last_len;
				probe_d.cur_len = ent_q.len;
			end
			if (probe_in.hit_here) begin
				probe_d.next_hole = hole;
				probe_d.next_len = ent_q.len;
			end
		end
		probe_d.hit_here = match;
		probe_d.last_hole = hole;
		probe_d.last_len = ent_q.len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q.owner <= '0;
			ent_q.len <= (IDX == 0) ? SW'(MEM_SIZE_RST) : '0;
			probe_q <= '0;
		end else begin
			ent_q <= ent_d;
			probe_q <= probe_d;
		end
	end

	assign ent = ent_q;
	assign probe_out = probe_q;

endmodule

// File: design/best_worst_fit_segment_allocator_unit.sv
// channel   | handshake               | payload
// ----------+-------------------------+--------------------------------------
// command   | start in, busy out      | cmd: func, proc_id, req_size
// result    | done out (one cycle)    | result: status, leftover, merged_size
// config    | cfg_valid in, cfg_ready | cfg_index, cfg_data
//
// one command at a time: after the accepting edge, the probe travels down the cell
// row and is captured at its end, the decide state plans zero to three edits, the
// edit state applies them one after another and the result state raises done; a new
// command is taken only once the unit is back in idle after done
// reset leaves one hole of 65535 (masked to SIZE_WIDTH) and best fit selected
// config is taken only while idle with start low; a write of memory_size
// reinitializes the table in the cycle of the transaction
// the receiver cannot stall: done marks each result for exactly one cycle
module best_worst_fit_segment_allocator_unit #(
	parameter int MAX_SEGMENTS = 16,
	parameter int SIZE_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  bwfsa_pkg::cmd_t                      cmd,
	output logic                                 done,
	output bwfsa_pkg::rsp_t                      result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bwfsa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [15:0]                          cfg_data
);
	import bwfsa_pkg::*;

	localparam int IW = (MAX_SEGMENTS > 2) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int SW = SIZE_WIDTH;

	// one table entry held by a cell
	typedef struct packed {
		logic [7:0]    owner;
		logic [SW-1:0] len;
	} entry_t;

	// broadcast edit command
	typedef struct packed {
		ed_op_t        op;
		logic [IW-1:0] pos;
		logic [7:0]    owner;
		logic [SW-1:0] len;
	} edit_t;

	// search packet handed from cell to cell
	typedef struct packed {
		logic          valid;
		logic          func;
		logic [7:0]    id;
		logic [SW-1:0] req;
		logic          worst;
		logic [CW-1:0] cnt;
		logic          found;
		logic [SW-1:0] best;
		logic [IW-1:0] pos;
		logic          hit_here;
		logic          prev_hole;
		logic [SW-1:0] prev_len;
		logic [SW-1:0] cur_len;
		logic          next_hole;
		logic [SW-1:0] next_len;
		logic          last_hole;
		logic [SW-1:0] last_len;
	} probe_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_EDIT,
		S_RESP
	} state_t;

	state_t state_q;
	logic fit_q;
	logic [CW-1:0] cnt_q;
	probe_t inj_q;
	probe_t fin_q;
	edit_t ed_q [3];
	logic [1:0] nops_q;
	logic [1:0] step_q;
	rsp_t res_q;

	edit_t edit_w;
	entry_t ent_pad [MAX_SEGMENTS + 2];
	probe_t prb_w [MAX_SEGMENTS + 1];
	probe_t launch_w;

	// plan worked out from the finished probe
	edit_t plan_ed [3];
	logic [1:0] plan_n;
	rsp_t plan_res;
	logic [SW-1:0] m3;
	logic [SW-1:0] m2p;
	logic [SW-1:0] m2n;

	logic cfg_wr;

	assign cfg_ready = (state_q == S_IDLE) && !start;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);
	assign result = res_q;

	// edge entries of the row read as free entries (owner zero) of length zero
	assign ent_pad[0] = '0;
	assign ent_pad[MAX_SEGMENTS + 1] = '0;
	assign prb_w[0] = inj_q;

	for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
		bwfsa_cell #(
			.IDX(g),
			.IW(IW),
			.CW(CW),
			.SW(SW),
			.entry_t(entry_t),
			.probe_t(probe_t),
			.edit_t(edit_t)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.edit(edit_w),
			.left(ent_pad[g]),
			.right(ent_pad[g + 2]),
			.ent(ent_pad[g + 1]),
			.probe_in(prb_w[g]),
			.probe_out(prb_w[g + 1])
		);
	end

	// probe launched into the first cell when a command is accepted
	always_comb begin
		launch_w = '0;
		launch_w.valid = 1'b1;
		launch_w.func = cmd.func;
		launch_w.id = cmd.proc_id;
		launch_w.req = SW'(cmd.req_size);
		launch_w.worst = fit_q;
		launch_w.cnt = cnt_q;
	end

	// edit broadcast: config reinit when idle, planned edits while editing
	always_comb begin
		edit_w = '0;
		if (cfg_wr && (cfg_index == CFG_MEM_SIZE)) begin
			edit_w.op = ED_INIT;
			edit_w.len = SW'(cfg_data);
		end else if (state_q == S_EDIT) begin
			edit_w = ed_q[step_q];
		end
	end

	// decide the outcome of the transaction and the edits it needs
	always_comb begin
		plan_ed[0] = '0;
		plan_ed[1] = '0;
		plan_ed[2] = '0;
		plan_n = 2'd0;
		plan_res = '0;
		m3 = fin_q.prev_len + fin_q.cur_len + fin_q.next_len;
		m2p = fin_q.prev_len + fin_q.cur_len;
		m2n = fin_q.cur_len + fin_q.next_len;
		if (fin_q.func == FN_ALLOC) begin
			if (!fin_q.found) begin
				plan_res.status = ST_NO_FIT;
			end else if (fin_q.best == '0) begin
				// exact fit: relabel the hole, works even with a full table
				plan_ed[0].op = ED_SET_OWNER;
				plan_ed[0].pos = fin_q.pos;
				plan_ed[0].owner = fin_q.id;
				plan_n = 2'd1;
			end else if (cnt_q >= CW'(MAX_SEGMENTS)) begin
				plan_res.status = ST_FULL;
			end else begin
				plan_ed[0].op = ED_INSERT;
				plan_ed[0].pos = fin_q.pos;
				plan_ed[0].owner = fin_q.id;
				plan_ed[0].len = fin_q.req;
				plan_ed[1].op = ED_SET_LEN;
				plan_ed[1].pos = fin_q.pos + IW'(1);
				plan_ed[1].len = fin_q.best;
				plan_n = 2'd2;
				plan_res.leftover = 16'(fin_q.best);
			end
		end else begin
			if (!fin_q.found) begin
				plan_res.status = ST_NOT_FOUND;
			end else if (fin_q.prev_hole && fin_q.next_hole) begin
				// both neighbors are holes: fold all three into the left one
				plan_ed[0].op = ED_SET_LEN;
				plan_ed[0].pos = fin_q.pos - IW'(1);
				plan_ed[0].len = m3;
				plan_ed[1].op = ED_REMOVE;
				plan_ed[1].pos = fin_q.pos;
				plan_ed[2].op = ED_REMOVE;
				plan_ed[2].pos = fin_q.pos;
				plan_n = 2'd3;
				plan_res.merged_size = 16'(m3);
			end else if (fin_q.prev_hole) begin
				plan_ed[0].op = ED_SET_LEN;
				plan_ed[0].pos = fin_q.pos - IW'(1);
				plan_ed[0].len = m2p;
				plan_ed[1].op = ED_REMOVE;
				plan_ed[1].pos = fin_q.pos;
				plan_n = 2'd2;
				plan_res.merged_size = 16'(m2p);
			end else if (fin_q.next_hole) begin
				plan_ed[0].op = ED_SET_LEN;
				plan_ed[0].pos = fin_q.pos + IW'(1);
				plan_ed[0].len = m2n;
				plan_ed[1].op = ED_REMOVE;
				plan_ed[1].pos = fin_q.pos;
				plan_n = 2'd2;
				plan_res.merged_size = 16'(m2n);
			end else begin
				plan_ed[0].op = ED_SET_OWNER;
				plan_ed[0].pos = fin_q.pos;
				plan_ed[0].owner = '0;
				plan_n = 2'd1;
				plan_res.merged_size = 16'(fin_q.cur_len);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fit_q <= FIT_BEST;
			cnt_q <= CW'(1);
			inj_q <= '0;
			fin_q <= '0;
			ed_q[0] <= '0;
			ed_q[1] <= '0;
			ed_q[2] <= '0;
			nops_q <= 2'd0;
			step_q <= 2'd0;
			res_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cfg_wr && (cfg_index == CFG_FIT_MODE)) begin
						fit_q <= cfg_data[0];
					end
					if (cfg_wr && (cfg_index == CFG_MEM_SIZE)) begin
						cnt_q <= CW'(1);
					end
					if (start) begin
						// launch the probe into the first cell
						inj_q <= launch_w;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// the probe enters the row for one cycle only
					inj_q.valid <= 1'b0;
					if (prb_w[MAX_SEGMENTS].valid) begin
						fin_q <= prb_w[MAX_SEGMENTS];
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					ed_q[0] <= plan_ed[0];
					ed_q[1] <= plan_ed[1];
					ed_q[2] <= plan_ed[2];
					nops_q <= plan_n;
					step_q <= 2'd0;
					res_q <= plan_res;
					state_q <= (plan_n == 2'd0) ? S_RESP : S_EDIT;
				end
				S_EDIT: begin
					// keep the segment count in step with the row
					if (ed_q[step_q].op == ED_INSERT) begin
						cnt_q <= cnt_q + CW'(1);
					end else if (ed_q[step_q].op == ED_REMOVE) begin
						cnt_q <= cnt_q - CW'(1);
					end
					step_q <= step_q + 2'd1;
					if (step_q == 2'(nops_q - 2'd1)) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a result always returns the unit to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("unit still busy after result");

	// an accepted transaction makes the unit busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("transaction not taken up");

	// the row never holds zero or more than its capacity
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q >= CW'(1)) && (cnt_q <= CW'(MAX_SEGMENTS)))
		else $error("segment count out of range");

	// table full is reported only when the row is at capacity
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_FULL)) |-> (cnt_q == CW'(MAX_SEGMENTS)))
		else $error("table full reported below capacity");

endmodule
